@@ rtl/affine_transform_3d_engine_assert.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the affine transform engine
// Same-cycle and next-cycle implications, clocked on clk, quiet in reset.
// ----------------------------------------------------------------------------
`ifndef AFFINE_TRANSFORM_3D_ENGINE_ASSERT_SVH
`define AFFINE_TRANSFORM_3D_ENGINE_ASSERT_SVH

// cond holds in the same cycle as the trigger
`define ATE_ASSERT_NOW(lbl, trig, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (trig) |-> (cond)) else $error(msg);

// cond holds in the cycle after the trigger
`define ATE_ASSERT_NEXT(lbl, trig, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (trig) |=> (cond)) else $error(msg);

`endif

@@ rtl/ate_pkg.sv @@
// ----------------------------------------------------------------------------
// ate_pkg
// Shared constants, types and arithmetic helpers of the affine engine.
// ----------------------------------------------------------------------------
package ate_pkg;

	localparam int FRAC_BITS  = 16;
	localparam int COEF_COUNT = 12;
	localparam int ADDR_W     = 4;
	localparam int RW         = FRAC_BITS + 2;   // rotation entry width
	localparam int DIV_STEPS  = FRAC_BITS + 1;
	localparam int DCNT_W     = $clog2(DIV_STEPS + 1);
	localparam int QPROD_N    = 10;              // quaternion products
	localparam int RENT_N     = 9;               // rotation entries

	localparam logic [2:0] OP_RESET     = 3'd0;
	localparam logic [2:0] OP_WRITE     = 3'd1;
	localparam logic [2:0] OP_APPLY     = 3'd2;
	localparam logic [2:0] OP_TRANSLATE = 3'd3;
	localparam logic [2:0] OP_SCALE     = 3'd4;
	localparam logic [2:0] OP_ROTATE    = 3'd5;

	typedef logic signed [31:0] coef_t;
	typedef logic signed [63:0] prod_t;
	typedef logic signed [RW-1:0] rent_t;

	localparam coef_t ONE   = coef_t'(64'd1 << FRAC_BITS);
	localparam coef_t Q_LIM = 32'sh4000_0000;

	typedef enum logic [3:0] {
		S_IDLE,
		S_EXEC,
		S_PASS,
		S_QMUL,
		S_QNORM,
		S_QDIV,
		S_RLOAD,
		S_RMUL,
		S_DONE
	} state_t;

	function automatic coef_t sat32(prod_t v);
		if (v > 64'sd2147483647)
			return 32'sh7FFF_FFFF;
		else if (v < -64'sd2147483648)
			return 32'sh8000_0000;
		else
			return coef_t'(v[31:0]);
	endfunction

	// round to nearest, ties toward plus infinity
	function automatic prod_t mulr(prod_t p);
		prod_t t;
		t = p + (prod_t'(1) <<< (FRAC_BITS - 1));
		return t >>> FRAC_BITS;
	endfunction

	// identity value of entry {row, col}
	function automatic coef_t ident(logic [ADDR_W-1:0] e);
		return (e[3:2] == e[1:0]) ? ONE : '0;
	endfunction

endpackage

@@ rtl/ate_div.sv @@
// ----------------------------------------------------------------------------
// ate_div
// Restoring divider: round(num * 2^FRAC_BITS / den), ties away from zero, |num| limited to den.
// ----------------------------------------------------------------------------
module ate_div (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  ate_pkg::prod_t      num,
	input  logic [63:0]         den,
	output logic                done,
	output ate_pkg::rent_t      quo
);

	logic                         busy_q;
	logic                         done_q;
	logic [ate_pkg::DCNT_W-1:0]   cnt_q;
	logic [63:0]                  rem_q;
	logic [63:0]                  den_q;
	logic [ate_pkg::RW-1:0]       qt_q;
	logic                         neg_q;
	ate_pkg::rent_t               quo_q;

	logic [63:0]                  mag;
	logic [63:0]                  magc;
	logic [63:0]                  rem_sh;
	logic                         ge;
	logic [ate_pkg::RW:0]         qinc;
	logic [ate_pkg::RW-1:0]       qr;

	always_comb begin
		mag    = num[63] ? 64'(-num) : 64'(num);
		magc   = (mag > den) ? den : mag;
		rem_sh = {rem_q[62:0], 1'b0};
		ge     = (rem_sh >= den_q);
		qinc   = {1'b0, qt_q} + (ate_pkg::RW+1)'(1);
		qr     = qinc[ate_pkg::RW:1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				if (cnt_q < ate_pkg::DCNT_W'(ate_pkg::DIV_STEPS)) begin
					cnt_q <= cnt_q + 1'b1;
				end else begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= (magc == den) ? '0 : magc;
			qt_q  <= ate_pkg::RW'(magc == den);
			neg_q <= num[63];
			den_q <= den;
		end else if (busy_q) begin
			if (cnt_q < ate_pkg::DCNT_W'(ate_pkg::DIV_STEPS)) begin
				rem_q <= ge ? (rem_sh - den_q) : rem_sh;
				qt_q  <= {qt_q[ate_pkg::RW-2:0], ge};
			end else begin
				quo_q <= neg_q ? -$signed(qr) : $signed(qr);
			end
		end
	end

	assign done = done_q;
	assign quo  = quo_q;

endmodule

@@ rtl/affine_transform_3d_engine.sv @@
// ----------------------------------------------------------------------------
// affine_transform_3d_engine
// 3x4 Q16.16 affine transform held in a small coefficient RAM; one
// operation per request: reset, write, apply, translate, scale, rotate.
// ----------------------------------------------------------------------------
//
//  channel | dir | signals                       | contents
//  --------+-----+-------------------------------+-----------------------------
//  s_*     | in  | s_tvalid s_tready s_tdata     | operation (tuser), operands
//          |     | s_tuser                       |
//  m_*     | out | m_tvalid m_tready m_tdata     | out_x/y/z (tdata), status
//          |     | m_tuser                       | (tuser)
//
//  Apply, translate and scale each make one pass over the coefficient RAM
//  (one coefficient RAM read per cycle, shared 32x32 multiplier); rotate
//  runs ten quaternion products, nine 17-step divisions, then four column
//  passes of 3 reads and 9 multiplies.
//  Reset (arst_n low) makes the matrix read back as identity via per-entry
//  valid bits; the reset operation clears those bits.
//  A new request is taken once the previous one has been handed to the
//  output register; while a stalled m_tready holds it full, the next result waits.
//
// ----------------------------------------------------------------------------
`include "affine_transform_3d_engine_assert.svh"

module affine_transform_3d_engine (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [167:0] s_tdata,  // coef_index[3:0], coef_value, vec_x, vec_y, vec_z, quat_w
	input  logic [2:0]   s_tuser,  // operation
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [95:0]  m_tdata,  // out_x[31:0], out_y[63:32], out_z[95:64]
	output logic [0:0]   m_tuser   // status
);

	ate_pkg::state_t st_q, st_d;

	// request payload
	logic [2:0]                   op_q;
	logic [ate_pkg::ADDR_W-1:0]   cidx_q;
	ate_pkg::coef_t               cval_q;
	ate_pkg::coef_t               v_q [3];    // x, y, z (pre-shifted for a large rotate)
	ate_pkg::coef_t               qw_q;
	logic                         status_q;

	// coefficient RAM, entry index is {row, col}
	ate_pkg::coef_t               coef_mem_q [ate_pkg::COEF_COUNT];
	logic [ate_pkg::COEF_COUNT-1:0] valid_q;
	ate_pkg::coef_t               mem_rd_q;
	logic                         rd_s1, rvld_s1;
	logic [ate_pkg::ADDR_W-1:0]   ridx_s1;
	ate_pkg::coef_t               rd_data;

	logic                         rd_go, wr_en, clr_valid;
	logic [ate_pkg::ADDR_W-1:0]   rd_addr, wr_addr;
	ate_pkg::coef_t               wr_data;

	// sequencing
	logic [ate_pkg::ADDR_W-1:0]   cnt_q;
	logic                         iss_q;

	// shared multiplier
	ate_pkg::coef_t               mul_a, mul_b;
	ate_pkg::prod_t               mul_p_q;
	ate_pkg::prod_t               acc_q;

	// apply / scale second stage
	logic                         p_s2;
	logic [ate_pkg::ADDR_W-1:0]   pidx_s2;
	ate_pkg::coef_t               rdd_s2;
	ate_pkg::coef_t               res_q [3];
	logic [1:0]                   vidx;

	// rotate
	ate_pkg::prod_t               pww_q, pxx_q, pyy_q, pzz_q, pxy_q;
	ate_pkg::prod_t               pwz_q, pxz_q, pwy_q, pyz_q, pwx_q;
	logic                         qs_s1;
	logic [ate_pkg::ADDR_W-1:0]   qst_s1;
	logic [63:0]                  n_q;
	logic [3:0]                   d_q;
	logic                         dwait_q;
	ate_pkg::rent_t               r_q [ate_pkg::RENT_N];
	ate_pkg::coef_t               col_q [3];
	logic [1:0]                   colj_q;
	logic [3:0]                   rt_q;
	logic [1:0]                   ri_q, rk_q;
	logic                         mv_s1;
	logic [1:0]                   mi_s1, mk_s1;
	logic                         div_go, div_done;
	ate_pkg::prod_t               div_num;
	ate_pkg::rent_t               div_quo;
	logic                         qzero;

	// output register
	logic                         m_tvalid_q;
	ate_pkg::coef_t               ox_q, oy_q, oz_q;
	logic                         ost_q;
	logic                         out_load;

	// input field split
	logic [3:0]                   in_idx;
	ate_pkg::coef_t               in_cv, in_x, in_y, in_z, in_w;
	logic                         in_big;

	assign in_idx = s_tdata[3:0];
	assign in_cv  = s_tdata[35:4];
	assign in_x   = s_tdata[67:36];
	assign in_y   = s_tdata[99:68];
	assign in_z   = s_tdata[131:100];
	assign in_w   = s_tdata[163:132];

	// any part at or beyond 2^30 in magnitude -> halve all four
	assign in_big = (in_x >= ate_pkg::Q_LIM) || (in_x <= -ate_pkg::Q_LIM) ||
	                (in_y >= ate_pkg::Q_LIM) || (in_y <= -ate_pkg::Q_LIM) ||
	                (in_z >= ate_pkg::Q_LIM) || (in_z <= -ate_pkg::Q_LIM) ||
	                (in_w >= ate_pkg::Q_LIM) || (in_w <= -ate_pkg::Q_LIM);

	assign s_tready = (st_q == ate_pkg::S_IDLE);
	assign qzero    = (qw_q == '0) && (v_q[0] == '0) && (v_q[1] == '0) && (v_q[2] == '0);
	assign rd_data  = rvld_s1 ? mem_rd_q : ate_pkg::ident(ridx_s1);
	assign out_load = (st_q == ate_pkg::S_DONE) && (!m_tvalid_q || m_tready);

	// v operand: column for apply, row for translate/scale
	assign vidx = (op_q == ate_pkg::OP_APPLY) ?
	              ((ridx_s1[1:0] == 2'd3) ? 2'd0 : ridx_s1[1:0]) : ridx_s1[3:2];

	// ------------------------------------------------------------------
	// next state and control
	// ------------------------------------------------------------------
	always_comb begin
		st_d      = st_q;
		rd_go     = 1'b0;
		rd_addr   = cnt_q;
		wr_en     = 1'b0;
		wr_addr   = ridx_s1;
		wr_data   = '0;
		clr_valid = 1'b0;
		div_go    = 1'b0;
		mul_a     = '0;
		mul_b     = '0;
		case (st_q)
			ate_pkg::S_IDLE: begin
				if (s_tvalid)
					st_d = ate_pkg::S_EXEC;
			end
			ate_pkg::S_EXEC: begin
				case (op_q)
					ate_pkg::OP_RESET: begin
						clr_valid = 1'b1;
						st_d      = ate_pkg::S_DONE;
					end
					ate_pkg::OP_WRITE: begin
						if (cidx_q < ate_pkg::ADDR_W'(ate_pkg::COEF_COUNT)) begin
							wr_en   = 1'b1;
							wr_addr = cidx_q;
							wr_data = cval_q;
						end
						st_d = ate_pkg::S_DONE;
					end
					ate_pkg::OP_APPLY, ate_pkg::OP_TRANSLATE, ate_pkg::OP_SCALE: begin
						st_d = ate_pkg::S_PASS;
					end
					ate_pkg::OP_ROTATE: begin
						st_d = qzero ? ate_pkg::S_DONE : ate_pkg::S_QMUL;
					end
					default: begin
						st_d = ate_pkg::S_DONE;
					end
				endcase
			end
			ate_pkg::S_PASS: begin
				rd_go = iss_q;
				mul_a = rd_data;
				mul_b = v_q[vidx];
				if (op_q == ate_pkg::OP_TRANSLATE && rd_s1 && ridx_s1[1:0] == 2'd3) begin
					wr_en   = 1'b1;
					wr_addr = ridx_s1;
					wr_data = ate_pkg::sat32(ate_pkg::prod_t'(rd_data) +
					                         ate_pkg::prod_t'(v_q[ridx_s1[3:2]]));
				end
				if (op_q == ate_pkg::OP_SCALE && p_s2) begin
					wr_en   = 1'b1;
					wr_addr = pidx_s2;
					wr_data = ate_pkg::sat32(ate_pkg::mulr(mul_p_q));
				end
				if (p_s2 && pidx_s2 == ate_pkg::ADDR_W'(ate_pkg::COEF_COUNT - 1))
					st_d = ate_pkg::S_DONE;
			end
			ate_pkg::S_QMUL: begin
				case (cnt_q)
					4'd0:    begin mul_a = qw_q;   mul_b = qw_q;   end
					4'd1:    begin mul_a = v_q[0]; mul_b = v_q[0]; end
					4'd2:    begin mul_a = v_q[1]; mul_b = v_q[1]; end
					4'd3:    begin mul_a = v_q[2]; mul_b = v_q[2]; end
					4'd4:    begin mul_a = v_q[0]; mul_b = v_q[1]; end
					4'd5:    begin mul_a = qw_q;   mul_b = v_q[2]; end
					4'd6:    begin mul_a = v_q[0]; mul_b = v_q[2]; end
					4'd7:    begin mul_a = qw_q;   mul_b = v_q[1]; end
					4'd8:    begin mul_a = v_q[1]; mul_b = v_q[2]; end
					default: begin mul_a = qw_q;   mul_b = v_q[0]; end
				endcase
				if (qs_s1 && qst_s1 == ate_pkg::ADDR_W'(ate_pkg::QPROD_N - 1))
					st_d = ate_pkg::S_QNORM;
			end
			ate_pkg::S_QNORM: begin
				st_d = ate_pkg::S_QDIV;
			end
			ate_pkg::S_QDIV: begin
				div_go = !dwait_q;
				if (div_done && d_q == 4'(ate_pkg::RENT_N - 1))
					st_d = ate_pkg::S_RLOAD;
			end
			ate_pkg::S_RLOAD: begin
				rd_go   = iss_q;
				rd_addr = {cnt_q[1:0], colj_q};
				if (rd_s1 && ridx_s1[3:2] == 2'd2)
					st_d = ate_pkg::S_RMUL;
			end
			ate_pkg::S_RMUL: begin
				mul_a = 32'(r_q[rt_q]);
				mul_b = col_q[rk_q];
				if (mv_s1 && mk_s1 == 2'd2) begin
					wr_en   = 1'b1;
					wr_addr = {mi_s1, colj_q};
					wr_data = ate_pkg::sat32(acc_q + ate_pkg::mulr(mul_p_q));
					if (mi_s1 == 2'd2)
						st_d = (colj_q == 2'd3) ? ate_pkg::S_DONE : ate_pkg::S_RLOAD;
				end
			end
			ate_pkg::S_DONE: begin
				if (!m_tvalid_q || m_tready)
					st_d = ate_pkg::S_IDLE;
			end
			default: begin
				st_d = ate_pkg::S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			st_q <= ate_pkg::S_IDLE;
		else
			st_q <= st_d;
	end

	// numerator of the rotation entry being divided
	always_comb begin
		case (d_q)
			4'd0:    div_num = pww_q + pxx_q - pyy_q - pzz_q;
			4'd1:    div_num = (pxy_q - pwz_q) <<< 1;
			4'd2:    div_num = (pxz_q + pwy_q) <<< 1;
			4'd3:    div_num = (pxy_q + pwz_q) <<< 1;
			4'd4:    div_num = pww_q + pyy_q - pxx_q - pzz_q;
			4'd5:    div_num = (pyz_q - pwx_q) <<< 1;
			4'd6:    div_num = (pxz_q - pwy_q) <<< 1;
			4'd7:    div_num = (pyz_q + pwx_q) <<< 1;
			default: div_num = pww_q + pzz_q - pxx_q - pyy_q;
		endcase
	end

	ate_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_go),
		.num    (div_num),
		.den    (n_q),
		.done   (div_done),
		.quo    (div_quo)
	);

	// ------------------------------------------------------------------
	// coefficient RAM
	// ------------------------------------------------------------------
	always_ff @(posedge clk) begin
		if (wr_en)
			coef_mem_q[wr_addr] <= wr_data;
		if (rd_go)
			mem_rd_q <= coef_mem_q[rd_addr];
		ridx_s1 <= rd_addr;
		rvld_s1 <= valid_q[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (clr_valid) begin
			valid_q <= '0;
		end else if (wr_en) begin
			valid_q[wr_addr] <= 1'b1;
		end
	end

	// ------------------------------------------------------------------
	// control counters and pipeline valids
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q      <= '0;
			iss_q      <= 1'b0;
			rd_s1      <= 1'b0;
			p_s2       <= 1'b0;
			qs_s1      <= 1'b0;
			mv_s1      <= 1'b0;
			d_q        <= '0;
			dwait_q    <= 1'b0;
			colj_q     <= '0;
			rt_q       <= '0;
			ri_q       <= '0;
			rk_q       <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			rd_s1 <= rd_go;
			p_s2  <= (st_q == ate_pkg::S_PASS) && rd_s1;
			qs_s1 <= (st_q == ate_pkg::S_QMUL) && iss_q;
			mv_s1 <= (st_q == ate_pkg::S_RMUL) && iss_q;
			case (st_q)
				ate_pkg::S_EXEC: begin
					cnt_q <= '0;
					iss_q <= 1'b1;
				end
				ate_pkg::S_PASS: begin
					if (iss_q) begin
						cnt_q <= cnt_q + 1'b1;
						if (cnt_q == ate_pkg::ADDR_W'(ate_pkg::COEF_COUNT - 1))
							iss_q <= 1'b0;
					end
				end
				ate_pkg::S_QMUL: begin
					if (iss_q) begin
						cnt_q <= cnt_q + 1'b1;
						if (cnt_q == ate_pkg::ADDR_W'(ate_pkg::QPROD_N - 1))
							iss_q <= 1'b0;
					end
				end
				ate_pkg::S_QNORM: begin
					d_q     <= '0;
					dwait_q <= 1'b0;
				end
				ate_pkg::S_QDIV: begin
					if (!dwait_q)
						dwait_q <= 1'b1;
					if (div_done) begin
						dwait_q <= 1'b0;
						d_q     <= d_q + 1'b1;
						colj_q  <= '0;
						cnt_q   <= '0;
						iss_q   <= 1'b1;
					end
				end
				ate_pkg::S_RLOAD: begin
					if (iss_q) begin
						cnt_q <= cnt_q + 1'b1;
						if (cnt_q == 4'd2)
							iss_q <= 1'b0;
					end
					if (rd_s1 && ridx_s1[3:2] == 2'd2) begin
						iss_q <= 1'b1;
						rt_q  <= '0;
						ri_q  <= '0;
						rk_q  <= '0;
					end
				end
				ate_pkg::S_RMUL: begin
					if (iss_q) begin
						rt_q <= rt_q + 1'b1;
						rk_q <= (rk_q == 2'd2) ? 2'd0 : rk_q + 1'b1;
						if (rk_q == 2'd2)
							ri_q <= ri_q + 1'b1;
						if (rt_q == 4'(ate_pkg::RENT_N - 1))
							iss_q <= 1'b0;
					end
					if (mv_s1 && mk_s1 == 2'd2 && mi_s1 == 2'd2) begin
						colj_q <= colj_q + 1'b1;
						cnt_q  <= '0;
						iss_q  <= 1'b1;
					end
				end
				default: begin
					iss_q <= 1'b0;
				end
			endcase
			if (m_tvalid_q && m_tready)
				m_tvalid_q <= 1'b0;
			if (out_load)
				m_tvalid_q <= 1'b1;
		end
	end

	// ------------------------------------------------------------------
	// datapath registers
	// ------------------------------------------------------------------
	always_ff @(posedge clk) begin
		mul_p_q <= mul_a * mul_b;
		pidx_s2 <= ridx_s1;
		rdd_s2  <= rd_data;
		qst_s1  <= cnt_q;
		mi_s1   <= ri_q;
		mk_s1   <= rk_q;

		if (s_tvalid && s_tready) begin
			op_q   <= s_tuser;
			cidx_q <= in_idx;
			cval_q <= in_cv;
			if (s_tuser == ate_pkg::OP_ROTATE && in_big) begin
				v_q[0] <= in_x >>> 1;
				v_q[1] <= in_y >>> 1;
				v_q[2] <= in_z >>> 1;
				qw_q   <= in_w >>> 1;
			end else begin
				v_q[0] <= in_x;
				v_q[1] <= in_y;
				v_q[2] <= in_z;
				qw_q   <= in_w;
			end
		end

		if (st_q == ate_pkg::S_EXEC) begin
			status_q <= (op_q == ate_pkg::OP_ROTATE) && qzero;
			acc_q    <= '0;
		end

		// apply: three rounded products then the translation term
		if (st_q == ate_pkg::S_PASS && p_s2 && op_q == ate_pkg::OP_APPLY) begin
			if (pidx_s2[1:0] == 2'd3) begin
				res_q[pidx_s2[3:2]] <= ate_pkg::sat32(acc_q + ate_pkg::prod_t'(rdd_s2));
				acc_q               <= '0;
			end else begin
				acc_q <= acc_q + ate_pkg::mulr(mul_p_q);
			end
		end

		if (qs_s1) begin
			case (qst_s1)
				4'd0:    pww_q <= mul_p_q;
				4'd1:    pxx_q <= mul_p_q;
				4'd2:    pyy_q <= mul_p_q;
				4'd3:    pzz_q <= mul_p_q;
				4'd4:    pxy_q <= mul_p_q;
				4'd5:    pwz_q <= mul_p_q;
				4'd6:    pxz_q <= mul_p_q;
				4'd7:    pwy_q <= mul_p_q;
				4'd8:    pyz_q <= mul_p_q;
				default: pwx_q <= mul_p_q;
			endcase
		end

		if (st_q == ate_pkg::S_QNORM)
			n_q <= 64'(pww_q) + 64'(pxx_q) + 64'(pyy_q) + 64'(pzz_q);

		if (div_done)
			r_q[d_q] <= div_quo;

		if (st_q == ate_pkg::S_RLOAD && rd_s1)
			col_q[ridx_s1[3:2]] <= rd_data;

		// rotate: one row of R times the held column
		if (st_q == ate_pkg::S_RMUL && mv_s1) begin
			if (mk_s1 == 2'd2)
				acc_q <= '0;
			else
				acc_q <= acc_q + ate_pkg::mulr(mul_p_q);
		end

		if (out_load) begin
			ox_q  <= (op_q == ate_pkg::OP_APPLY) ? res_q[0] : '0;
			oy_q  <= (op_q == ate_pkg::OP_APPLY) ? res_q[1] : '0;
			oz_q  <= (op_q == ate_pkg::OP_APPLY) ? res_q[2] : '0;
			ost_q <= status_q;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {oz_q, oy_q, ox_q};
	assign m_tuser  = ost_q;

	// ------------------------------------------------------------------
	// assertions
	// ------------------------------------------------------------------
	`ATE_ASSERT_NOW(a_wr_range, wr_en, wr_addr < ate_pkg::ADDR_W'(ate_pkg::COEF_COUNT), "coefficient write out of range")
	`ATE_ASSERT_NOW(a_rw_clash, rd_go && wr_en, rd_addr != wr_addr, "read and write hit the same entry")
	`ATE_ASSERT_NOW(a_div_ctx, div_done, st_q == ate_pkg::S_QDIV, "divider finished outside rotate")
	`ATE_ASSERT_NEXT(a_out_load, st_q == ate_pkg::S_DONE && !m_tvalid_q, m_tvalid_q && st_q == ate_pkg::S_IDLE, "result not loaded")

endmodule

@@ tb/tb_affine_transform_3d_engine.sv @@
// ----------------------------------------------------------------------------
// tb_affine_transform_3d_engine
// Self-checking bench: random and directed matrix operations are streamed in,
// every result is compared against an in-bench fixed-point transform model.
// ----------------------------------------------------------------------------
module tb_affine_transform_3d_engine;

	localparam int  MAX_CYCLES = 2000000;
	localparam logic [2:0] OP_UNUSED6 = 3'd6;
	localparam logic [2:0] OP_UNUSED7 = 3'd7;

	typedef struct packed {
		logic [31:0] z;
		logic [31:0] y;
		logic [31:0] x;
		logic        status;
	} xform_result_t;

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         s_tvalid = 1'b0;
	logic         s_tready;
	logic [167:0] s_tdata = '0;   // coef_index[3:0], coef_value, vec_x, vec_y, vec_z, quat_w
	logic [2:0]   s_tuser = '0;   // operation
	logic         m_tvalid;
	logic         m_tready = 1'b0;
	logic [95:0]  m_tdata;        // out_x, out_y, out_z
	logic [0:0]   m_tuser;        // status

	// shadow copy of the coefficient store
	longint       model_coefs [ate_pkg::COEF_COUNT];
	xform_result_t expected_results [$];
	int           mismatch_count = 0;
	int           cycle_count = 0;

	affine_transform_3d_engine u_dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
	);

	always #2 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > MAX_CYCLES) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	// ---------------- fixed-point model ----------------
	function automatic longint floor_shift(longint v, int s);
		return v >>> s;
	endfunction

	function automatic longint clamp32(longint v);
		if (v > 64'sd2147483647) return 64'sd2147483647;
		if (v < -64'sd2147483648) return -64'sd2147483648;
		return v;
	endfunction

	function automatic longint round_mul(longint a, longint b);
		return floor_shift(a * b + (64'sd1 <<< (ate_pkg::FRAC_BITS - 1)), ate_pkg::FRAC_BITS);
	endfunction

	// num/den in fixed point, ties away from zero
	function automatic longint quat_ratio(longint num, longint unsigned den);
		logic neg;
		longint unsigned mag, q, rem;
		neg = num < 0;
		mag = neg ? -num : num;
		if (mag > den) mag = den;
		q = (mag >= den) ? 1 : 0;
		rem = mag - q * den;
		for (int i = 0; i < ate_pkg::FRAC_BITS + 1; i++) begin
			rem = rem << 1;
			q = q << 1;
			if (rem >= den) begin
				rem = rem - den;
				q = q | 1;
			end
		end
		q = (q + 1) >> 1;
		return neg ? -longint'(q) : longint'(q);
	endfunction

	function automatic void load_identity_model();
		for (int i = 0; i < ate_pkg::COEF_COUNT; i++) model_coefs[i] = 0;
		model_coefs[0] = 64'sd1 <<< ate_pkg::FRAC_BITS;
		model_coefs[5] = 64'sd1 <<< ate_pkg::FRAC_BITS;
		model_coefs[10] = 64'sd1 <<< ate_pkg::FRAC_BITS;
	endfunction

	// false when the quaternion has zero norm
	function automatic bit rotate_model(longint w, longint x, longint y, longint z);
		longint lim, ww, xx, yy, zz, acc;
		longint r [9];
		longint nb [ate_pkg::COEF_COUNT];
		longint unsigned n;
		lim = 64'sd1 <<< 30;
		if (w >= lim || w <= -lim || x >= lim || x <= -lim ||
		    y >= lim || y <= -lim || z >= lim || z <= -lim) begin
			w = w >>> 1; x = x >>> 1; y = y >>> 1; z = z >>> 1;
		end
		ww = w * w; xx = x * x; yy = y * y; zz = z * z;
		n = longint'(ww) + longint'(xx) + longint'(yy) + longint'(zz);
		if (n == 0) return 1'b0;
		r[0] = quat_ratio(ww + xx - yy - zz, n);
		r[4] = quat_ratio(ww + yy - xx - zz, n);
		r[8] = quat_ratio(ww + zz - xx - yy, n);
		r[1] = quat_ratio(2 * (x * y - w * z), n);
		r[2] = quat_ratio(2 * (x * z + w * y), n);
		r[3] = quat_ratio(2 * (x * y + w * z), n);
		r[5] = quat_ratio(2 * (y * z - w * x), n);
		r[6] = quat_ratio(2 * (x * z - w * y), n);
		r[7] = quat_ratio(2 * (y * z + w * x), n);
		for (int i = 0; i < 3; i++)
			for (int j = 0; j < 4; j++) begin
				acc = 0;
				for (int k = 0; k < 3; k++)
					acc += round_mul(r[i * 3 + k], model_coefs[k * 4 + j]);
				nb[i * 4 + j] = clamp32(acc);
			end
		for (int i = 0; i < ate_pkg::COEF_COUNT; i++) model_coefs[i] = nb[i];
		return 1'b1;
	endfunction

	function automatic xform_result_t predict_transform(logic [2:0] op, logic [3:0] idx,
			logic signed [31:0] cv, logic signed [31:0] vx, logic signed [31:0] vy,
			logic signed [31:0] vz, logic signed [31:0] qw);
		xform_result_t res;
		longint v [3];
		longint acc;
		longint outv [3];
		res = '0;
		v[0] = vx; v[1] = vy; v[2] = vz;
		outv = '{0, 0, 0};
		case (op)
			ate_pkg::OP_RESET: load_identity_model();
			ate_pkg::OP_WRITE: if (idx < ate_pkg::COEF_COUNT) model_coefs[idx] = cv;
			ate_pkg::OP_APPLY: begin
				for (int i = 0; i < 3; i++) begin
					acc = model_coefs[i * 4 + 3];
					for (int j = 0; j < 3; j++)
						acc += round_mul(model_coefs[i * 4 + j], v[j]);
					outv[i] = clamp32(acc);
				end
			end
			ate_pkg::OP_TRANSLATE: begin
				for (int i = 0; i < 3; i++)
					model_coefs[i * 4 + 3] = clamp32(model_coefs[i * 4 + 3] + v[i]);
			end
			ate_pkg::OP_SCALE: begin
				for (int i = 0; i < 3; i++)
					for (int j = 0; j < 4; j++)
						model_coefs[i * 4 + j] = clamp32(round_mul(v[i], model_coefs[i * 4 + j]));
			end
			ate_pkg::OP_ROTATE: res.status = !rotate_model(qw, vx, vy, vz);
			default: ;
		endcase
		res.x = outv[0][31:0];
		res.y = outv[1][31:0];
		res.z = outv[2][31:0];
		return res;
	endfunction

	// ---------------- stimulus ----------------
	// one request: random gap, then hold valid until accepted
	task automatic send_request(logic [2:0] op, logic [3:0] idx, logic [31:0] cv,
			logic [31:0] vx, logic [31:0] vy, logic [31:0] vz, logic [31:0] qw);
		int gap;
		gap = $urandom_range(0, 11);
		if (gap != 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= op;
		s_tdata  <= {qw, vz, vy, vx, cv, idx};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		// accepted at this edge; valid drops with the next gap or drain
		expected_results.push_back(predict_transform(op, idx, cv, vx, vy, vz, qw));
	endtask

	function automatic logic [31:0] rand_q();
		case ($urandom_range(0, 5))
			0: return 32'h8000_0000;
			1: return 32'h7FFF_FFFF;
			2, 3: return $urandom_range(0, 32'h3_FFFF) - 32'h2_0000;   // within +-2.0
			default: return $urandom;
		endcase
	endfunction

	task automatic wait_drained();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (expected_results.size() != 0) @(posedge clk);
	endtask

	task automatic test_directed_ops();
		// apply through identity, then write extremes
		send_request(ate_pkg::OP_APPLY, 0, 0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0001_0000, 0);
		send_request(ate_pkg::OP_WRITE, 0, 32'h7FFF_FFFF, 0, 0, 0, 0);
		send_request(ate_pkg::OP_WRITE, 11, 32'h8000_0000, 0, 0, 0, 0);
		// index beyond the store is dropped
		send_request(ate_pkg::OP_WRITE, 15, 32'h1234_5678, 0, 0, 0, 0);
		send_request(ate_pkg::OP_WRITE, 12, 32'hFFFF_FFFF, 0, 0, 0, 0);
		send_request(ate_pkg::OP_APPLY, 0, 0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0);
		send_request(ate_pkg::OP_TRANSLATE, 0, 0, 32'h7FFF_FFFF, 32'h8000_0000,
			32'h0000_8000, 0);
		send_request(ate_pkg::OP_SCALE, 0, 0, 32'h8000_0000, 32'h0002_0000, 32'h7FFF_FFFF, 0);
		send_request(ate_pkg::OP_APPLY, 0, 0, 32'hFFFF_8000, 32'h0000_8000, 32'h8000_0000, 0);
		send_request(ate_pkg::OP_RESET, 0, 0, 0, 0, 0, 0);
		// zero quaternion is rejected
		send_request(ate_pkg::OP_ROTATE, 0, 0, 0, 0, 0, 0);
		send_request(ate_pkg::OP_ROTATE, 0, 0, 0, 0, 0, 32'h0001_0000);
		send_request(ate_pkg::OP_ROTATE, 0, 0, 32'h0000_B505, 0, 0, 32'h0000_B505);
		// large parts take the pre-shift; parts just below 2^30 do not
		send_request(ate_pkg::OP_ROTATE, 0, 0, 32'h8000_0000, 32'h7FFF_FFFF, 32'h4000_0000,
			32'h8000_0000);
		send_request(ate_pkg::OP_ROTATE, 0, 0, 32'h4000_0000, 0, 0, 0);
		send_request(ate_pkg::OP_ROTATE, 0, 0, 32'hC000_0001, 32'h3FFF_FFFF, 1, 32'hFFFF_FFFF);
		send_request(ate_pkg::OP_APPLY, 0, 0, 32'h0001_0000, 32'h0002_0000, 32'hFFFD_0000, 0);
		send_request(OP_UNUSED6, 4'hF, 32'hFFFF_FFFF, 1, 2, 3, 4);
		send_request(OP_UNUSED7, 0, 0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
			32'hFFFF_FFFF);
		send_request(ate_pkg::OP_RESET, 4'hF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
			32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_request(ate_pkg::OP_APPLY, 0, 0, 32'h0003_0000, 32'h0000_0001, 32'hFFFF_FFFF, 0);
	endtask

	task automatic test_random_ops(int count);
		logic [2:0] op;
		int sel;
		for (int n = 0; n < count; n++) begin
			sel = $urandom_range(0, 99);
			if (sel < 30) op = ate_pkg::OP_APPLY;
			else if (sel < 45) op = ate_pkg::OP_WRITE;
			else if (sel < 58) op = ate_pkg::OP_TRANSLATE;
			else if (sel < 70) op = ate_pkg::OP_SCALE;
			else if (sel < 88) op = ate_pkg::OP_ROTATE;
			else if (sel < 94) op = ate_pkg::OP_RESET;
			else op = 3'($urandom_range(6, 7));
			if (op == ate_pkg::OP_ROTATE && $urandom_range(0, 15) == 0)
				send_request(op, 4'($urandom), $urandom, 0, 0, 0, 0);
			else
				send_request(op, 4'($urandom_range(0, 15)), rand_q(), rand_q(), rand_q(),
					rand_q(), rand_q());
			if (n == count / 2) wait_drained();   // hold off until the pipe empties
		end
	endtask

	// ---------------- result checking ----------------
	initial begin
		xform_result_t exp_res, got;
		int stall;
		wait (arst_n === 1'b1);
		forever begin
			stall = $urandom_range(0, 11);
			if (stall != 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_tready <= 1'b1;
			@(posedge clk);
			while (m_tvalid !== 1'b1) @(posedge clk);
			got = {m_tdata[95:64], m_tdata[63:32], m_tdata[31:0], m_tuser[0]};
			if (expected_results.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= 10)
					$display("unexpected result x=%h y=%h z=%h st=%b",
						got.x, got.y, got.z, got.status);
			end else begin
				exp_res = expected_results.pop_front();
				if (got != exp_res) begin
					mismatch_count++;
					if (mismatch_count <= 10)
						$display("exp x=%h y=%h z=%h st=%b got x=%h y=%h z=%h st=%b",
							exp_res.x, exp_res.y, exp_res.z, exp_res.status,
							got.x, got.y, got.z, got.status);
				end
			end
		end
	end

	initial begin
		load_identity_model();
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed_ops();
		test_random_ops(550);
		wait_drained();
		repeat (300) @(posedge clk);
		if (mismatch_count == 0 && expected_results.size() == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

@@ sim.f @@
+incdir+rtl
rtl/ate_pkg.sv
rtl/ate_div.sv
rtl/affine_transform_3d_engine.sv
tb/tb_affine_transform_3d_engine.sv
